### sv/efp_pkg.sv
// shared types, constants and helpers for the escape-time fractal pixel block
// no dependencies; imported by every module of the block
`default_nettype none

package efp_pkg;

    localparam int COORD_W    = 32;
    localparam int STEP_W     = 31;
    localparam int ROW_W      = 7;
    localparam int COL_W      = 8;
    localparam int FRAC_BITS  = 26;
    localparam int INDEX_W    = 3;
    localparam int QUEUE_DEPTH = 2;

    // escape threshold |z|^2 > 4 in the squared scale
    localparam logic [63:0] ESCAPE_LIMIT = 64'd4 << (2 * FRAC_BITS);

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    localparam logic                      RST_MODE_JULIA = 1'b1;
    localparam logic signed [COORD_W-1:0] RST_C_REAL     = -32'sd46976205;
    localparam logic signed [COORD_W-1:0] RST_C_IMAG     = 32'sd18119393;
    localparam logic signed [COORD_W-1:0] RST_VIEW_LEFT  = -32'sd100663296;
    localparam logic signed [COORD_W-1:0] RST_VIEW_TOP   = 32'sd100663296;
    localparam logic [STEP_W-1:0]         RST_REAL_STEP  = 31'd1585248;
    localparam logic [STEP_W-1:0]         RST_IMAG_STEP  = 31'd1585248;

    typedef enum logic [INDEX_W-1:0] {
        REG_MODE_JULIA = 3'd0,
        REG_C_REAL     = 3'd1,
        REG_C_IMAG     = 3'd2,
        REG_VIEW_LEFT  = 3'd3,
        REG_VIEW_TOP   = 3'd4,
        REG_REAL_STEP  = 3'd5,
        REG_IMAG_STEP  = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_ADD
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_UPD
    } back_state_t;

    typedef struct packed {
        logic [ROW_W-1:0] pixel_row;
        logic [COL_W-1:0] pixel_col;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] iterations;
        logic [2:0] level;
    } pixel_out_t;

    typedef struct packed {
        logic                      mode_julia;
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
        logic signed [COORD_W-1:0] view_left;
        logic signed [COORD_W-1:0] view_top;
        logic [STEP_W-1:0]         real_step;
        logic [STEP_W-1:0]         imag_step;
    } cfg_t;

    // starting z and constant c of one pixel
    typedef struct packed {
        logic signed [COORD_W-1:0] zr;
        logic signed [COORD_W-1:0] zi;
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[COORD_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/efp_front.sv
// front end: takes a pixel, maps it to the complex plane and sets up z and c
// depends on efp_pkg; feeds efp_queue
`default_nettype none

module efp_front
    import efp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire pixel_in_t pixel,
    input  wire cfg_t      cfg,
    input  wire q_status_t q_stat,
    output logic           busy,
    output logic           push,
    output job_t           job
);

    front_state_t state_reg, state_next;

    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic [COL_W+STEP_W-1:0] re_prod_reg, re_prod_next;
    logic [ROW_W+STEP_W-1:0] im_prod_reg, im_prod_next;

    logic signed [63:0]         re_sum, im_sum;
    logic signed [COORD_W-1:0]  pre, pim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FR_IDLE && start)
        begin
            row_reg <= pixel.pixel_row;
            col_reg <= pixel.pixel_col;
        end
        re_prod_reg <= re_prod_next;
        im_prod_reg <= im_prod_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: if (start) state_next = FR_MUL;
            FR_MUL:  state_next = FR_ADD;
            FR_ADD:  if (!q_stat.full) state_next = FR_IDLE;
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb
    begin
        re_prod_next = (COL_W+STEP_W)'(col_reg) * (COL_W+STEP_W)'(cfg.real_step);
        im_prod_next = (ROW_W+STEP_W)'(row_reg) * (ROW_W+STEP_W)'(cfg.imag_step);

        re_sum = $signed({{(64-COORD_W){cfg.view_left[COORD_W-1]}}, cfg.view_left})
               + $signed({{(64-COL_W-STEP_W){1'b0}}, re_prod_reg});
        im_sum = $signed({{(64-COORD_W){cfg.view_top[COORD_W-1]}}, cfg.view_top})
               - $signed({{(64-ROW_W-STEP_W){1'b0}}, im_prod_reg});
        pre = sat32(re_sum);
        pim = sat32(im_sum);

        busy = (state_reg != FR_IDLE);
        push = (state_reg == FR_ADD) && !q_stat.full;

        if (cfg.mode_julia)
        begin
            job.zr = pre;
            job.zi = pim;
            job.cr = cfg.c_real;
            job.ci = cfg.c_imag;
        end
        else
        begin
            job.zr = '0;
            job.zi = '0;
            job.cr = pre;
            job.ci = pim;
        end
    end

endmodule

`default_nettype wire

### sv/efp_queue.sv
// two-entry item queue between the front end and the iteration engine
// depends on efp_pkg
`default_nettype none

module efp_queue
    import efp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    input  wire logic pop,
    output job_t      pop_data,
    output q_status_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t mem_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // depth is a power of two, so the pointers wrap on their own
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
        pop_data    = mem_reg[rd_ptr_reg];
        stat.full   = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.empty  = (count_reg == '0);
    end

endmodule

`default_nettype wire

### sv/efp_back.sv
// iteration engine: z = z*z + c with escape test, then count and colour level
// depends on efp_pkg; drains efp_queue
`default_nettype none

module efp_back
    import efp_pkg::*;
#(
    parameter int MAX_ITERATIONS = 128
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_stat,
    input  wire job_t      q_data,
    output logic           pop,
    output logic           done,
    output pixel_out_t     result
);

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

    localparam logic [31:0] LOW_LIMIT = 32'(7 * MAX_ITERATIONS);
    localparam logic [31:0] BAND_OFS  = 32'(9 * MAX_ITERATIONS);
    localparam logic [31:0] BAND_UNIT = 32'(186 * MAX_ITERATIONS);

    back_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] zr_reg, zr_next;
    logic signed [COORD_W-1:0] zi_reg, zi_next;
    logic signed [COORD_W-1:0] cr_reg, cr_next;
    logic signed [COORD_W-1:0] ci_reg, ci_next;
    logic signed [63:0]        prr_reg, prr_next;
    logic signed [63:0]        pii_reg, pii_next;
    logic signed [63:0]        pri_reg, pri_next;
    logic [CNT_W-1:0]          k_reg, k_next;
    logic                      done_reg, done_next;
    pixel_out_t                result_reg, result_next;

    logic                      escaped;
    logic                      finish;
    logic [63:0]               mag;
    logic signed [COORD_W-1:0] rr, ii, ri;
    logic signed [63:0]        re_sum, im_sum;
    logic [CNT_W-1:0]          count;
    logic [31:0]               count_w, band_val;
    logic [2:0]                level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        prr_reg    <= prr_next;
        pii_reg    <= pii_next;
        pri_reg    <= pri_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    // escape test on the squares of the current z, then the update
    always_comb
    begin
        mag     = 64'(prr_reg) + 64'(pii_reg);
        escaped = (k_reg != '0) && (mag > ESCAPE_LIMIT);
        finish  = escaped || (k_reg == CNT_W'(MAX_ITERATIONS));
        count   = escaped ? k_reg - CNT_W'(1) : k_reg;

        rr = sat32(prr_reg >>> FRAC_BITS);
        ii = sat32(pii_reg >>> FRAC_BITS);
        ri = sat32(pri_reg >>> (FRAC_BITS - 1));
        re_sum = 64'(rr) - 64'(ii) + 64'(cr_reg);
        im_sum = 64'(ri) + 64'(ci_reg);

        count_w  = 32'(count);
        band_val = 32'd1200 * count_w + BAND_OFS;
        if (count_w >= 32'(MAX_ITERATIONS))
            level = 3'd7;
        else if (32'd100 * count_w < LOW_LIMIT)
            level = 3'd0;
        else
            level = 3'd1 + 3'(band_val >= BAND_UNIT) + 3'(band_val >= 32'd2 * BAND_UNIT)
                  + 3'(band_val >= 32'd3 * BAND_UNIT) + 3'(band_val >= 32'd4 * BAND_UNIT)
                  + 3'(band_val >= 32'd5 * BAND_UNIT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_stat.empty) state_next = BK_MUL;
            BK_MUL:  state_next = BK_UPD;
            BK_UPD:  state_next = finish ? BK_IDLE : BK_MUL;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        zr_next     = zr_reg;
        zi_next     = zi_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        k_next      = k_reg;
        prr_next    = 64'(zr_reg) * 64'(zr_reg);
        pii_next    = 64'(zi_reg) * 64'(zi_reg);
        pri_next    = 64'(zr_reg) * 64'(zi_reg);
        done_next   = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop     = 1'b1;
                    zr_next = q_data.zr;
                    zi_next = q_data.zi;
                    cr_next = q_data.cr;
                    ci_next = q_data.ci;
                    k_next  = '0;
                end
            end
            BK_MUL:
            begin
            end
            BK_UPD:
            begin
                if (finish)
                begin
                    done_next              = 1'b1;
                    result_next.iterations = 8'(count);
                    result_next.level      = level;
                end
                else
                begin
                    zr_next = sat32(re_sum);
                    zi_next = sat32(im_sum);
                    k_next  = k_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        done   = done_reg;
        result = result_reg;
    end

endmodule

`default_nettype wire

### sv/escape_time_fractal_pixel.sv
// Escape-time fractal pixel, Mandelbrot or Julia, Q5.26 fixed point.
// The front end takes one item when start is high and busy is low, maps it to the plane
// and queues it; the iteration engine loads an item, then runs each iteration as square
// products, then update and escape test, until the item escapes or reaches MAX_ITERATIONS.
// The shared complex-square unit sets the sustained rate. Each result is shown for one
// cycle with done high and must be taken then; nothing holds it back.
// depends on efp_pkg, efp_front, efp_queue, efp_back
`default_nettype none

module escape_time_fractal_pixel
    import efp_pkg::*;
#(
    parameter int MAX_ITERATIONS = 128
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire pixel_in_t          pixel,
    output logic                    done,
    output pixel_out_t              result,
    input  wire logic               write_en,
    input  wire logic [INDEX_W-1:0] write_index,
    input  wire logic [COORD_W-1:0] write_data
);

    cfg_t      cfg_reg;
    q_status_t q_stat;
    job_t      push_data, pop_data;
    logic      push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_julia <= RST_MODE_JULIA;
            cfg_reg.c_real     <= RST_C_REAL;
            cfg_reg.c_imag     <= RST_C_IMAG;
            cfg_reg.view_left  <= RST_VIEW_LEFT;
            cfg_reg.view_top   <= RST_VIEW_TOP;
            cfg_reg.real_step  <= RST_REAL_STEP;
            cfg_reg.imag_step  <= RST_IMAG_STEP;
        end
        else if (write_en)
        begin
            unique case (write_index)
                REG_MODE_JULIA: cfg_reg.mode_julia <= write_data[0];
                REG_C_REAL:     cfg_reg.c_real     <= write_data;
                REG_C_IMAG:     cfg_reg.c_imag     <= write_data;
                REG_VIEW_LEFT:  cfg_reg.view_left  <= write_data;
                REG_VIEW_TOP:   cfg_reg.view_top   <= write_data;
                REG_REAL_STEP:  cfg_reg.real_step  <= write_data[STEP_W-1:0];
                REG_IMAG_STEP:  cfg_reg.imag_step  <= write_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    efp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .pixel  (pixel),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .busy   (busy),
        .push   (push),
        .job    (push_data)
    );

    efp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    efp_back #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (pop_data),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

### dv/tb_top.sv
// testbench for escape_time_fractal_pixel: pixels go in through start/busy and
// results are checked as done strobes them, against an escape-time predictor
// depends on efp_pkg and the block's rtl
`default_nettype none

module tb_top
    import efp_pkg::*;
();

    localparam int ITER_CAP = 128;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint WORD_MAX = 2147483647;
    localparam longint WORD_MIN = -longint'(2147483647) - 1;
    localparam logic [2:0] LEVEL_BACKGROUND = 3'd0;
    localparam logic [2:0] LEVEL_FIRST_BAND = 3'd1;
    localparam logic [2:0] LEVEL_LAST_BAND = 3'd6;
    localparam logic [2:0] LEVEL_INSIDE = 3'd7;
    localparam logic [INDEX_W-1:0] SPARE_INDEX = 3'd7;
    localparam logic [COORD_W-1:0] Q_ONE = 32'd67108864;
    localparam logic [COORD_W-1:0] Q_TWO = 32'd134217728;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    pixel_in_t pixel = '0;
    logic done;
    pixel_out_t result;
    logic write_en = 1'b0;
    logic [INDEX_W-1:0] write_index = '0;
    logic [COORD_W-1:0] write_data = '0;

    cfg_t model_cfg;
    pixel_in_t pixel_queue[$];
    pixel_out_t expected_pixels[$];
    pixel_out_t want;
    bit took_item = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int pixels_accepted = 0;
    int results_checked = 0;
    int inside_count = 0;
    int instant_count = 0;
    int views_run = 0;

    escape_time_fractal_pixel #(
        .MAX_ITERATIONS(ITER_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel),
        .done(done),
        .result(result),
        .write_en(write_en),
        .write_index(write_index),
        .write_data(write_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [COORD_W-1:0] clamp_q(input longint v);
        longint c;
        c = (v > WORD_MAX) ? WORD_MAX : (v < WORD_MIN) ? WORD_MIN : v;
        return c[COORD_W-1:0];
    endfunction

    function automatic pixel_out_t predict_pixel(input pixel_in_t px);
        longint re_pt;
        longint im_pt;
        longint sq_r;
        longint sq_i;
        longint unsigned mag;
        logic signed [COORD_W-1:0] zr, zi, cr, ci, pre, pim, rr, ii, ri;
        int unsigned n;
        int unsigned band;
        pixel_out_t res;
        re_pt = longint'(model_cfg.view_left)
              + longint'(px.pixel_col) * longint'(model_cfg.real_step);
        im_pt = longint'(model_cfg.view_top)
              - longint'(px.pixel_row) * longint'(model_cfg.imag_step);
        pre = clamp_q(re_pt);
        pim = clamp_q(im_pt);
        if (model_cfg.mode_julia)
        begin
            zr = pre;
            zi = pim;
            cr = model_cfg.c_real;
            ci = model_cfg.c_imag;
        end
        else
        begin
            zr = '0;
            zi = '0;
            cr = pre;
            ci = pim;
        end
        n = ITER_CAP;
        for (int k = 0; k < ITER_CAP; k++)
        begin
            rr = clamp_q((longint'(zr) * longint'(zr)) >>> FRAC_BITS);
            ii = clamp_q((longint'(zi) * longint'(zi)) >>> FRAC_BITS);
            ri = clamp_q((longint'(zr) * longint'(zi)) >>> (FRAC_BITS - 1));
            zr = clamp_q(longint'(rr) - longint'(ii) + longint'(cr));
            zi = clamp_q(longint'(ri) + longint'(ci));
            sq_r = longint'(zr) * longint'(zr);
            sq_i = longint'(zi) * longint'(zi);
            mag = $unsigned(sq_r) + $unsigned(sq_i);
            if (mag > ESCAPE_LIMIT)
            begin
                n = k;
                break;
            end
        end
        res.iterations = n[7:0];
        if (n >= ITER_CAP)
            res.level = LEVEL_INSIDE;
        else if (n * 100 < 7 * ITER_CAP)
            res.level = LEVEL_BACKGROUND;
        else
        begin
            band = 1 + (1200 * n + 9 * ITER_CAP) / (186 * ITER_CAP);
            if (band > LEVEL_LAST_BAND)
                band = LEVEL_LAST_BAND;
            if (band < LEVEL_FIRST_BAND)
                band = LEVEL_FIRST_BAND;
            res.level = band[2:0];
        end
        return res;
    endfunction

    // driver: bursts of items with random gaps, noise on the pixel bus when idle
    always @(negedge clk)
    begin
        if (took_item)
        begin
            pixel_queue.delete(0);
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: gap_left = 0;
                    9: gap_left = $urandom_range(20, 300);
                    default: gap_left = $urandom_range(1, 12);
                endcase
            end
        end
        if (!rst_n || pixel_queue.size() == 0 || gap_left > 0)
        begin
            if (gap_left > 0 && pixel_queue.size() != 0)
                gap_left--;
            start <= 1'b0;
            pixel <= pixel_in_t'($urandom);
        end
        else
        begin
            start <= 1'b1;
            pixel <= pixel_queue[0];
        end
    end

    // monitor: results first, then the item taken at this edge
    always @(posedge clk)
    begin
        took_item = rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: iterations %0d level %0d",
                       result.iterations, result.level);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (result.iterations !== want.iterations)
                begin
                    $error("iterations: expected %0d, got %0d",
                           want.iterations, result.iterations);
                    fail_count++;
                end
                if (result.level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, result.level);
                    fail_count++;
                end
                results_checked++;
            end
        end
        if (took_item)
        begin
            want = predict_pixel(pixel);
            expected_pixels.push_back(want);
            pixels_accepted++;
            if (want.level == LEVEL_INSIDE)
                inside_count++;
            if (want.iterations == 0)
                instant_count++;
        end
        if (took_item || (rst_n && done) ||
            (pixel_queue.size() == 0 && expected_pixels.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [COORD_W-1:0] value);
        @(negedge clk);
        write_en <= 1'b1;
        write_index <= idx;
        write_data <= value;
        @(negedge clk);
        write_en <= 1'b0;
        case (idx)
            REG_MODE_JULIA: model_cfg.mode_julia = value[0];
            REG_C_REAL: model_cfg.c_real = value;
            REG_C_IMAG: model_cfg.c_imag = value;
            REG_VIEW_LEFT: model_cfg.view_left = value;
            REG_VIEW_TOP: model_cfg.view_top = value;
            REG_REAL_STEP: model_cfg.real_step = value[STEP_W-1:0];
            REG_IMAG_STEP: model_cfg.imag_step = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_block();
        while (pixel_queue.size() != 0 || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // unused upper bits of the mode and step words carry random junk
    task automatic load_view(input logic julia, input logic [COORD_W-1:0] cr,
                             input logic [COORD_W-1:0] ci, input logic [COORD_W-1:0] left,
                             input logic [COORD_W-1:0] top, input logic [COORD_W-1:0] rstep,
                             input logic [COORD_W-1:0] istep);
        logic [COORD_W-1:0] mode_word;
        drain_block();
        mode_word = $urandom;
        mode_word[0] = julia;
        if ($urandom_range(0, 1))
            rstep[COORD_W-1] = ~rstep[COORD_W-1];
        if ($urandom_range(0, 1))
            istep[COORD_W-1] = ~istep[COORD_W-1];
        write_reg(REG_MODE_JULIA, mode_word);
        write_reg(REG_C_REAL, cr);
        write_reg(REG_C_IMAG, ci);
        write_reg(REG_VIEW_LEFT, left);
        write_reg(REG_VIEW_TOP, top);
        write_reg(REG_REAL_STEP, rstep);
        write_reg(REG_IMAG_STEP, istep);
        views_run++;
    endtask

    task automatic queue_pixel(input int row, input int col);
        pixel_in_t px;
        px.pixel_row = row[ROW_W-1:0];
        px.pixel_col = col[COL_W-1:0];
        pixel_queue.push_back(px);
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            queue_pixel($urandom_range(0, 127), $urandom_range(0, 255));
    endtask

    initial
    begin
        model_cfg.mode_julia = RST_MODE_JULIA;
        model_cfg.c_real = RST_C_REAL;
        model_cfg.c_imag = RST_C_IMAG;
        model_cfg.view_left = RST_VIEW_LEFT;
        model_cfg.view_top = RST_VIEW_TOP;
        model_cfg.real_step = RST_REAL_STEP;
        model_cfg.imag_step = RST_IMAG_STEP;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        views_run = 1;

        // reset view, julia
        queue_pixel(0, 0);
        queue_pixel(127, 255);
        queue_pixel(0, 255);
        queue_pixel(127, 0);
        queue_pixel(64, 128);
        queue_random(200);

        // mandelbrot over the reset view
        drain_block();
        write_reg(REG_MODE_JULIA, 32'd0);
        queue_pixel(64, 85);
        queue_pixel(0, 0);
        queue_pixel(127, 255);
        queue_random(300);

        // c = 0 everywhere, never escapes
        load_view(1'b0, '0, '0, '0, '0, '0, '0);
        queue_pixel(0, 0);
        queue_pixel(127, 255);

        // c = -2, |z|^2 sits exactly on the limit
        load_view(1'b0, '0, '0, -Q_TWO, '0, '0, '0);
        queue_pixel(5, 5);

        // julia from z = 0, c = 2 then just above 2
        load_view(1'b1, Q_TWO, '0, '0, '0, '0, '0);
        queue_pixel(3, 9);
        drain_block();
        write_reg(REG_C_REAL, Q_TWO + 32'd1);
        queue_pixel(100, 200);

        // saturating corners
        load_view(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_pixel(0, 0);
        queue_pixel(127, 255);
        queue_pixel(0, 255);
        queue_pixel(127, 0);
        drain_block();
        write_reg(REG_MODE_JULIA, 32'd0);
        queue_pixel(127, 255);
        queue_pixel(0, 0);
        queue_random(40);

        // write to the spare index must change nothing
        drain_block();
        write_reg(SPARE_INDEX, $urandom);
        queue_pixel(64, 128);

        for (int p = 0; p < 7; p++)
        begin
            if (p == 6)
                load_view(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            else if (p % 2 == 0)
                load_view(1'b0, $urandom, $urandom,
                          -$urandom_range(Q_ONE, 32'd167772160),
                          $urandom_range(32'd33554432, 32'd100663296),
                          $urandom_range(1, 786432), $urandom_range(1, 786432));
            else
                load_view(1'b1,
                          $urandom_range(0, Q_TWO) - Q_ONE,
                          $urandom_range(0, Q_TWO) - Q_ONE,
                          -$urandom_range(32'd33554432, 32'd107374182),
                          $urandom_range(32'd33554432, 32'd100663296),
                          $urandom_range(1, 786432), $urandom_range(1, 786432));
            queue_random(140);
        end

        drain_block();
        $display("%0d pixels taken, %0d results checked over %0d view settings",
                 pixels_accepted, results_checked, views_run);
        $display("%0d pixels inside the set, %0d escaped on the first iteration",
                 inside_count, instant_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### escape_time_fractal_pixel.f
sv/efp_pkg.sv
sv/efp_front.sv
sv/efp_queue.sv
sv/efp_back.sv
sv/escape_time_fractal_pixel.sv
dv/tb_top.sv
